/* rtl/cap_pkg.sv */
`timescale 1ns / 1ps

package cap_pkg;

    // fixed widths of the sample and phase ports
    localparam int unsigned IN_WIDTH     = 32;
    localparam int unsigned PHASE_WIDTH  = 30;

    // defaults for the top level parameters
    localparam int unsigned ITERATIONS_DEF   = 27;
    localparam int unsigned FRAC_BITS_DEF    = 27;
    localparam int unsigned SAMPLE_WIDTH_DEF = 32;

    // pi/4 scaled by 2^62
    localparam logic [63:0] QPI_SCALED62 = 64'h3243F6A8885A308D;

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(2^-i) scaled by 2^62, taylor series with truncated terms
    function automatic logic [63:0] atan_scaled62(input int unsigned i);
        logic [63:0] sum;
        logic [63:0] t;
        int unsigned d;
        int unsigned e;
        logic        done;
        sum  = '0;
        done = 1'b0;
        if (i == 0) begin
            return QPI_SCALED62;
        end
        for (int unsigned k = 0; k < 32; k++) begin
            d = 2 * k + 1;
            e = i * d;
            if (e > 62) begin
                done = 1'b1;
            end
            if (!done) begin
                t = udiv64(64'd1 << (62 - e), 64'(d));
                if (k[0]) begin
                    sum = sum - t;
                end else begin
                    sum = sum + t;
                end
            end
        end
        return sum;
    endfunction

    // rounded arctangent table entry with frac fraction bits
    function automatic logic [63:0] atan_entry(input int unsigned i, input int unsigned frac);
        return (atan_scaled62(i) + (64'd1 << (61 - frac))) >> (62 - frac);
    endfunction

    // rounded pi/2 with frac fraction bits
    function automatic logic [63:0] half_pi(input int unsigned frac);
        return (QPI_SCALED62 + (64'd1 << (60 - frac))) >> (61 - frac);
    endfunction

endpackage

/* rtl/cordic_atan2_phase.sv */
// cordic_atan2_phase: pipelined cordic vectoring atan2, phase in radians
// a request passes stage 0, one register per iteration, then the phase register
// throughput: one request per cycle, set by one registered stage per cordic iteration
// the receiver cannot stall: o_valid is a single-cycle strobe, o_busy is low outside reset
// reset (i_rst_n low, synchronous) clears all valid bits; o_busy is high while reset is held
`timescale 1ns / 1ps

module cordic_atan2_phase #(
    parameter int unsigned ITERATIONS   = cap_pkg::ITERATIONS_DEF,
    parameter int unsigned FRAC_BITS    = cap_pkg::FRAC_BITS_DEF,
    parameter int unsigned SAMPLE_WIDTH = cap_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  logic signed [cap_pkg::IN_WIDTH-1:0]    i_in_phase,
    input  logic signed [cap_pkg::IN_WIDTH-1:0]    i_quadrature,
    output logic                                   o_valid,
    output logic signed [cap_pkg::PHASE_WIDTH-1:0] o_phase
);

    // x and y carry two guard bits: one for negating the most negative
    // sample, one for the cordic gain (about 1.65 * sqrt 2)
    localparam int unsigned XW = SAMPLE_WIDTH + 2;
    // |z| stays below pi/2 + sum of atan(2^-i) < 3.32 rad, so F + 3 bits signed
    localparam int unsigned ZW = FRAC_BITS + 3;
    localparam int unsigned PW = cap_pkg::PHASE_WIDTH;
    // width used for the final saturation compare
    localparam int unsigned SW = (ZW > PW) ? ZW : PW;

    localparam logic signed [ZW-1:0] HALF_PI = ZW'(cap_pkg::half_pi(FRAC_BITS));
    localparam logic signed [SW-1:0] LIM_HI  = SW'((64'd1 << (PW - 1)) - 64'd1);
    localparam logic signed [SW-1:0] LIM_LO  = -LIM_HI - SW'(1);

    // request handshake: taken whenever start is high outside reset
    logic w_accept;
    assign o_busy   = ~i_rst_n;
    assign w_accept = i_start & ~o_busy;

    // stage s holds the vector after s iterations; stage 0 is the pre-rotated input
    logic signed [XW-1:0] r_x   [ITERATIONS+1];
    logic signed [XW-1:0] r_y   [ITERATIONS+1];
    logic signed [ZW-1:0] r_z   [ITERATIONS+1];
    logic                 r_zro [ITERATIONS+1];
    logic                 r_vld [ITERATIONS+1];

    wire signed [XW-1:0] n_x   [ITERATIONS+1];
    wire signed [XW-1:0] n_y   [ITERATIONS+1];
    wire signed [ZW-1:0] n_z   [ITERATIONS+1];
    wire                 n_zro [ITERATIONS+1];
    wire                 n_vld [ITERATIONS+1];

    // ---------------------------------------------------------------
    // input stage: keep the low SAMPLE_WIDTH bits, sign extend, and move
    // left half plane vectors into the right half plane by a quarter turn
    // ---------------------------------------------------------------
    logic signed [XW-1:0] w_xi;
    logic signed [XW-1:0] w_yi;
    logic signed [XW-1:0] w_x0;
    logic signed [XW-1:0] w_y0;
    logic signed [ZW-1:0] w_z0;

    assign w_xi = XW'($signed(i_in_phase[SAMPLE_WIDTH-1:0]));
    assign w_yi = XW'($signed(i_quadrature[SAMPLE_WIDTH-1:0]));

    always_comb begin
        w_x0 = w_xi;
        w_y0 = w_yi;
        w_z0 = '0;
        if (w_xi[XW-1]) begin
            if (!w_yi[XW-1]) begin
                // quadrant II, negative I with Q zero lands here too
                w_x0 = w_yi;
                w_y0 = -w_xi;
                w_z0 = HALF_PI;
            end else begin
                // quadrant III
                w_x0 = -w_yi;
                w_y0 = w_xi;
                w_z0 = -HALF_PI;
            end
        end
    end

    assign n_x[0]   = w_x0;
    assign n_y[0]   = w_y0;
    assign n_z[0]   = w_z0;
    assign n_zro[0] = (w_xi == '0) && (w_yi == '0);
    assign n_vld[0] = w_accept;

    // ---------------------------------------------------------------
    // one register stage per iteration: rotate toward y = 0 and
    // accumulate the matching arctangent table entry
    // ---------------------------------------------------------------
    for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
        localparam logic signed [ZW-1:0] ATAN_K = ZW'(cap_pkg::atan_entry(k, FRAC_BITS));

        logic signed [XW-1:0] w_xs;
        logic signed [XW-1:0] w_ys;

        // arithmetic shifts floor toward minus infinity
        assign w_xs = r_x[k] >>> k;
        assign w_ys = r_y[k] >>> k;

        assign n_x[k+1]   = r_y[k][XW-1] ? (r_x[k] - w_ys) : (r_x[k] + w_ys);
        assign n_y[k+1]   = r_y[k][XW-1] ? (r_y[k] + w_xs) : (r_y[k] - w_xs);
        assign n_z[k+1]   = r_y[k][XW-1] ? (r_z[k] - ATAN_K) : (r_z[k] + ATAN_K);
        assign n_zro[k+1] = r_zro[k];
        assign n_vld[k+1] = r_vld[k];
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s <= ITERATIONS; s++) begin
            r_x[s]   <= n_x[s];
            r_y[s]   <= n_y[s];
            r_z[s]   <= n_z[s];
            r_zro[s] <= n_zro[s];
        end
        if (!i_rst_n) begin
            for (int s = 0; s <= ITERATIONS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s <= ITERATIONS; s++) begin
                r_vld[s] <= n_vld[s];
            end
        end
    end

    // ---------------------------------------------------------------
    // output stage: zero vector gives phase 0, otherwise clamp the
    // angle to the signed phase range
    // ---------------------------------------------------------------
    logic signed [SW-1:0] w_zext;
    logic signed [SW-1:0] w_zsat;
    logic signed [PW-1:0] n_phase;
    logic signed [PW-1:0] r_phase;
    logic                 r_valid;

    assign w_zext = SW'(r_z[ITERATIONS]);

    always_comb begin
        if (w_zext > LIM_HI) begin
            w_zsat = LIM_HI;
        end else if (w_zext < LIM_LO) begin
            w_zsat = LIM_LO;
        end else begin
            w_zsat = w_zext;
        end
        n_phase = r_zro[ITERATIONS] ? '0 : PW'(w_zsat);
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_vld[ITERATIONS];
        end
    end

    assign o_valid = r_valid;
    assign o_phase = r_phase;

endmodule
